// ===== rtl/core/multi_link_process_queue_manager_top_assert.svh =====
// Assertion macros for the multi-link queue manager.
`ifndef MULTI_LINK_PROCESS_QUEUE_MANAGER_TOP_ASSERT_SVH
`define MULTI_LINK_PROCESS_QUEUE_MANAGER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MLQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define MLQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/mlq_pkg.sv =====
// Package of shared types and codes for the multi-link queue manager.
`default_nettype none
package mlq_pkg;
  localparam int unsigned FIELD_ENTRY_W = 5;
  localparam int unsigned FIELD_SLOT_W = 2;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE_HEAD = 3'd1,
    ACT_REMOVE_NAMED = 3'd2,
    ACT_PEEK = 3'd3,
    ACT_ALLOC = 3'd4,
    ACT_FREE = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  typedef struct packed {
    logic found_valid;
    logic [FIELD_ENTRY_W-1:0] found_entry;
    logic new_tail_valid;
    logic [FIELD_ENTRY_W-1:0] new_tail_entry;
    logic [FIELD_SLOT_W-1:0] new_tail_slot;
    logic [1:0] status;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/core/mlq_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module mlq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/mlq_seq.sv =====
// Sequencer that walks the link memory one access at a time.
`default_nettype none
module mlq_seq
  import mlq_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 32,
  parameter int unsigned NUM_SLOTS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [2:0]           action,
  input  wire logic                 tv,
  input  wire logic [FIELD_ENTRY_W-1:0] te,
  input  wire logic [FIELD_SLOT_W-1:0]  ts,
  input  wire logic [FIELD_ENTRY_W-1:0] pe_in,
  output logic                      busy,
  output logic                      done,
  output result_t                   res
);
  localparam int unsigned EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned LINKS = NUM_ENTRIES * NUM_SLOTS;
  localparam int unsigned LW = $clog2(LINKS);
  localparam int unsigned NW = $clog2(LINKS + 1);
  localparam int unsigned CW = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned MW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SCW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SLOT, S_INS_RD, S_INS_WR, S_RD_TAIL, S_HEAD, S_WALK, S_STEP,
    S_UNL_RD, S_UNL_WR, S_FIFO_RD, S_FIFO_GET, S_FREE_CLR, S_DONE
  } state_t;

  state_t state;
  logic [2:0] act;
  logic [EW-1:0] t_e, p_e, pr_e, c_e;
  logic [SW-1:0] t_s, pr_s, c_s, slot;
  logic [SCW-1:0] scan;
  logic [NW-1:0] steps;
  logic t_v;

  // Link memory holds {entry, slot} per (entry, slot) address.
  logic lk_we;
  logic [LW-1:0] lk_addr;
  logic [EW+SW-1:0] lk_wdata, lk_rdata;
  logic [NUM_SLOTS-1:0] in_use [NUM_ENTRIES];
  logic [MW-1:0] mcount [NUM_ENTRIES];

  logic ff_we;
  logic [EW-1:0] ff_addr, ff_wdata, ff_rdata;
  logic [EW-1:0] rd_ptr, wr_ptr;
  logic [CW-1:0] fcount;
  logic [NUM_ENTRIES-1:0] ff_written;

  mlq_ram #(.WIDTH(EW + SW), .DEPTH(LINKS)) u_link (
    .clk(clk), .we(lk_we), .addr(lk_addr), .wdata(lk_wdata), .rdata(lk_rdata)
  );
  mlq_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_fifo (
    .clk(clk), .we(ff_we), .addr(ff_addr), .wdata(ff_wdata), .rdata(ff_rdata)
  );

  function automatic logic [LW-1:0] lk(input logic [EW-1:0] e, input logic [SW-1:0] s);
    lk = LW'(e) * LW'(NUM_SLOTS) + LW'(s);
  endfunction

  logic [EW-1:0] rd_e;
  logic [SW-1:0] rd_s;
  assign rd_e = lk_rdata[EW+SW-1:SW];
  assign rd_s = lk_rdata[SW-1:0];

  logic te_ok, pe_ok;
  assign te_ok = (32'(te) < NUM_ENTRIES) && (32'(ts) < NUM_SLOTS);
  assign pe_ok = 32'(pe_in) < NUM_ENTRIES;

  always_comb begin
    lk_we = 1'b0;
    lk_addr = lk(t_e, t_s);
    lk_wdata = {t_e, t_s};
    ff_we = 1'b0;
    ff_addr = rd_ptr;
    ff_wdata = p_e;
    case (state)
      S_INS_RD: lk_addr = lk(t_e, t_s);
      S_INS_WR: begin
        lk_we = 1'b1;
        lk_addr = lk(p_e, slot);
        lk_wdata = t_v ? lk_rdata : {p_e, slot};
      end
      S_WALK: lk_addr = lk(c_e, c_s);
      S_UNL_RD: lk_addr = lk(c_e, c_s);
      S_UNL_WR: begin
        lk_we = 1'b1;
        lk_addr = lk(pr_e, pr_s);
        lk_wdata = (act == ACT_INSERT) ? {p_e, slot} : lk_rdata;
      end
      S_FREE_CLR: begin
        ff_we = 1'b1;
        ff_addr = wr_ptr;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    done <= !rst && (state == S_DONE);
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        mcount[i] <= '0;
        in_use[i] <= '0;
      end
      rd_ptr <= '0;
      wr_ptr <= '0;
      fcount <= CW'(NUM_ENTRIES);
      ff_written <= '0;
      res <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            act <= action;
            t_v <= tv;
            t_e <= EW'(te);
            t_s <= SW'(ts);
            p_e <= EW'(pe_in);
            scan <= '0;
            res <= '{found_valid: 1'b0, found_entry: '0, new_tail_valid: tv,
                     new_tail_entry: tv ? te : '0, new_tail_slot: tv ? ts : '0,
                     status: ST_FAIL};
            case (action)
              ACT_INSERT: state <= (pe_ok && !(tv && !te_ok)) ? S_SLOT : S_DONE;
              ACT_REMOVE_HEAD, ACT_PEEK: state <= (tv && te_ok) ? S_RD_TAIL : S_DONE;
              ACT_REMOVE_NAMED: state <= (tv && te_ok && pe_ok) ? S_RD_TAIL : S_DONE;
              ACT_ALLOC: state <= (fcount != '0) ? S_FIFO_RD : S_DONE;
              ACT_FREE: state <= (pe_ok && 32'(fcount) < NUM_ENTRIES) ? S_FREE_CLR : S_DONE;
              default: state <= S_DONE;
            endcase
          end
        end
        S_SLOT: begin
          if (32'(scan) == NUM_SLOTS) begin
            res.status <= ST_NO_SLOT;
            state <= S_DONE;
          end else if (!in_use[p_e][SW'(scan)]) begin
            slot <= SW'(scan);
            state <= S_INS_RD;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          in_use[p_e][slot] <= 1'b1;
          mcount[p_e] <= mcount[p_e] + 1'b1;
          res <= '{found_valid: 1'b0, found_entry: '0, new_tail_valid: 1'b1,
                   new_tail_entry: FIELD_ENTRY_W'(p_e), new_tail_slot: FIELD_SLOT_W'(slot),
                   status: ST_OK};
          state <= t_v ? S_UNL_WR : S_DONE;
          pr_e <= t_e;
          pr_s <= t_s;
        end
        S_RD_TAIL: state <= S_HEAD;
        S_HEAD: begin
          pr_e <= t_e;
          pr_s <= t_s;
          c_e <= rd_e;
          c_s <= rd_s;
          steps <= '0;
          if (act != ACT_REMOVE_NAMED) begin
            res.found_valid <= 1'b1;
            res.found_entry <= FIELD_ENTRY_W'(rd_e);
            res.status <= ST_OK;
            if (act == ACT_REMOVE_HEAD && !(rd_e == t_e && rd_s == t_s)) begin
              state <= S_UNL_RD;
            end else begin
              state <= S_DONE;
              if (act == ACT_REMOVE_HEAD) begin
                in_use[t_e][t_s] <= 1'b0;
                if (mcount[t_e] != '0) mcount[t_e] <= mcount[t_e] - 1'b1;
                res.new_tail_valid <= 1'b0;
                res.new_tail_entry <= '0;
                res.new_tail_slot <= '0;
              end
            end
          end else if (rd_e == t_e && rd_s == t_s) begin
            state <= S_DONE;
            if (t_e == p_e) begin
              in_use[t_e][t_s] <= 1'b0;
              if (mcount[t_e] != '0) mcount[t_e] <= mcount[t_e] - 1'b1;
              res <= '{found_valid: 1'b1, found_entry: FIELD_ENTRY_W'(t_e),
                       new_tail_valid: 1'b0, new_tail_entry: '0, new_tail_slot: '0,
                       status: ST_OK};
            end
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (c_e == p_e) begin
            res.found_valid <= 1'b1;
            res.found_entry <= FIELD_ENTRY_W'(c_e);
            res.status <= ST_OK;
            if (c_e == t_e && c_s == t_s) begin
              res.new_tail_entry <= FIELD_ENTRY_W'(pr_e);
              res.new_tail_slot <= FIELD_SLOT_W'(pr_s);
            end
            state <= S_UNL_RD;
          end else if ((c_e == t_e && c_s == t_s) || 32'(steps) >= LINKS) begin
            state <= S_DONE;
          end else begin
            pr_e <= c_e;
            pr_s <= c_s;
            steps <= steps + 1'b1;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          c_e <= rd_e;
          c_s <= rd_s;
          state <= S_WALK;
        end
        S_UNL_RD: state <= S_UNL_WR;
        S_UNL_WR: begin
          if (act != ACT_INSERT) begin
            in_use[c_e][c_s] <= 1'b0;
            if (mcount[c_e] != '0) mcount[c_e] <= mcount[c_e] - 1'b1;
          end
          state <= S_DONE;
        end
        S_FIFO_RD: state <= S_FIFO_GET;
        S_FIFO_GET: begin
          res.found_valid <= 1'b1;
          res.found_entry <= FIELD_ENTRY_W'(ff_written[rd_ptr] ? ff_rdata : rd_ptr);
          res.status <= ST_OK;
          rd_ptr <= (32'(rd_ptr) + 1 == NUM_ENTRIES) ? '0 : rd_ptr + 1'b1;
          fcount <= fcount - 1'b1;
          state <= S_DONE;
        end
        S_FREE_CLR: begin
          ff_written[wr_ptr] <= 1'b1;
          wr_ptr <= (32'(wr_ptr) + 1 == NUM_ENTRIES) ? '0 : wr_ptr + 1'b1;
          fcount <= fcount + 1'b1;
          in_use[p_e] <= '0;
          mcount[p_e] <= '0;
          res.status <= ST_OK;
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // The walk reads the link at (c_e, c_s) in the walk state and takes it up in the step state.
  `include "multi_link_process_queue_manager_top_assert.svh"
  `MLQ_ASSERT(a_fcount_range, 1'b1, 32'(fcount) <= NUM_ENTRIES, "free count out of range")
  `MLQ_ASSERT_NEXT(a_done_idle, done, state == S_IDLE, "done outside idle return")
  `MLQ_ASSERT(a_no_start_busy, state != S_IDLE, !done, "done while busy")
endmodule
`default_nettype wire

// ===== rtl/core/multi_link_process_queue_manager_top.sv =====
// Top level of the multi-link circular queue manager.
// Channel | Dir | Fields
// s_axis  | in  | tdata: action[2:0] tail_valid[3] tail_entry[8:4] tail_slot[10:9] entry[15:11]
// m_axis  | out | tdata: found_valid found_entry new_tail_valid new_tail_entry new_tail_slot status
// A refused request returns its result without touching the link memory; a named remove
// walks the queue link by link, each step waiting on a registered link-memory read.
// Reset is synchronous and clears control state; no clearing pass is needed.
// A new request is taken only once the previous result has left the output register.
`default_nettype none
module multi_link_process_queue_manager_top
  import mlq_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 32,
  parameter int unsigned NUM_SLOTS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // action, tail_valid, tail_entry, tail_slot, entry
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // found_valid, found_entry, new_tail_valid, new_tail_entry, new_tail_slot, status
  output logic [15:0]      m_axis_tdata
);
  logic busy, done;
  result_t res;
  logic start;

  assign s_axis_tready = !busy && !m_axis_tvalid && !done;
  assign start = s_axis_tvalid && s_axis_tready;

  mlq_seq #(.NUM_ENTRIES(NUM_ENTRIES), .NUM_SLOTS(NUM_SLOTS)) u_seq (
    .clk(clk), .rst(rst), .start(start),
    .action(s_axis_tdata[2:0]), .tv(s_axis_tdata[3]),
    .te(s_axis_tdata[8:4]), .ts(s_axis_tdata[10:9]), .pe_in(s_axis_tdata[15:11]),
    .busy(busy), .done(done), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata <= {res.status, res.new_tail_slot, res.new_tail_entry,
                       res.new_tail_valid, res.found_entry, res.found_valid};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb_multi_link_process_queue_manager_top.sv =====
// Self-checking testbench for the multi-link circular queue manager.
module tb_multi_link_process_queue_manager_top;
  import mlq_pkg::*;

  localparam int NENT = 32;
  localparam int NSLOT = 4;
  localparam int NLINK = NENT * NSLOT;
  localparam int NQUEUE = 4;
  localparam int RANDOM_REQUESTS = 1600;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

  typedef struct packed {
    bit fv;
    bit [4:0] fe;
    bit ntv;
    bit [4:0] nte;
    bit [1:0] nts;
    status_t st;
  } res_t;

  typedef struct packed {
    logic [2:0] act;
    bit tv;
    bit [4:0] te;
    bit [1:0] ts;
    bit [4:0] ent;
    bit typed;
    res_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  multi_link_process_queue_manager_top u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the link memory, the slot flags and the free pool.
  bit [4:0] link_entry [NLINK];
  bit [1:0] link_slot [NLINK];
  bit slot_used [NLINK];
  bit link_written [NLINK];
  bit [4:0] pool [NENT];
  int pool_count = NENT;
  int pool_rd = 0;
  int pool_wr = 0;

  res_t pending_results [$];
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  bit q_valid [NQUEUE];
  bit [4:0] q_entry [NQUEUE];
  bit [1:0] q_slot [NQUEUE];
  bit [4:0] q_last [NQUEUE];

  row_t dir_rows [] = '{
    '{ACT_PEEK, 1'b0, 5'd0, 2'd0, 5'd0, 1'b1, '{1'b0, 5'd0, 1'b0, 5'd0, 2'd0, ST_FAIL}},
    '{ACT_FREE, 1'b0, 5'd0, 2'd0, 5'd3, 1'b1, '{1'b0, 5'd0, 1'b0, 5'd0, 2'd0, ST_FAIL}},
    '{ACT_UNUSED_6, 1'b0, 5'd0, 2'd0, 5'd0, 1'b1, '{1'b0, 5'd0, 1'b0, 5'd0, 2'd0, ST_FAIL}},
    '{ACT_UNUSED_7, 1'b0, 5'd0, 2'd0, 5'd0, 1'b1, '{1'b0, 5'd0, 1'b0, 5'd0, 2'd0, ST_FAIL}},
    '{ACT_ALLOC, 1'b0, 5'd0, 2'd0, 5'd0, 1'b1, '{1'b1, 5'd0, 1'b0, 5'd0, 2'd0, ST_OK}},
    '{ACT_INSERT, 1'b0, 5'd0, 2'd0, 5'd0, 1'b0, '0},
    '{ACT_INSERT, 1'b1, 5'd0, 2'd0, 5'd31, 1'b0, '0},
    '{ACT_INSERT, 1'b1, 5'd31, 2'd0, 5'd0, 1'b0, '0},
    '{ACT_INSERT, 1'b0, 5'd0, 2'd0, 5'd0, 1'b0, '0},
    '{ACT_INSERT, 1'b0, 5'd0, 2'd0, 5'd0, 1'b0, '0},
    '{ACT_INSERT, 1'b0, 5'd0, 2'd0, 5'd0, 1'b1, '{1'b0, 5'd0, 1'b0, 5'd0, 2'd0, ST_NO_SLOT}},
    '{ACT_PEEK, 1'b1, 5'd0, 2'd1, 5'd0, 1'b0, '0},
    '{ACT_REMOVE_NAMED, 1'b1, 5'd0, 2'd1, 5'd31, 1'b0, '0},
    '{ACT_REMOVE_NAMED, 1'b1, 5'd0, 2'd1, 5'd5, 1'b0, '0},
    '{ACT_REMOVE_NAMED, 1'b1, 5'd0, 2'd1, 5'd0, 1'b0, '0},
    '{ACT_REMOVE_HEAD, 1'b1, 5'd0, 2'd1, 5'd0, 1'b0, '0},
    '{ACT_REMOVE_NAMED, 1'b1, 5'd0, 2'd2, 5'd0, 1'b0, '0},
    '{ACT_REMOVE_NAMED, 1'b1, 5'd0, 2'd3, 5'd7, 1'b0, '0},
    '{ACT_REMOVE_HEAD, 1'b1, 5'd0, 2'd3, 5'd0, 1'b0, '0},
    '{ACT_REMOVE_HEAD, 1'b0, 5'd0, 2'd0, 5'd0, 1'b1, '{1'b0, 5'd0, 1'b0, 5'd0, 2'd0, ST_FAIL}},
    '{ACT_FREE, 1'b0, 5'd0, 2'd0, 5'd0, 1'b0, '0},
    '{ACT_ALLOC, 1'b0, 5'd0, 2'd0, 5'd0, 1'b0, '0},
    '{ACT_INSERT, 1'b0, 5'd0, 2'd0, 5'd31, 1'b0, '0},
    '{ACT_REMOVE_NAMED, 1'b1, 5'd31, 2'd0, 5'd31, 1'b0, '0}
  };

  function automatic int link_index(bit [4:0] e, bit [1:0] s);
    return int'(e) * NSLOT + int'(s);
  endfunction

  function automatic void unlink_after(bit [4:0] pe, bit [1:0] ps, bit [4:0] ce, bit [1:0] cs);
    int kp;
    int kc;
    kp = link_index(pe, ps);
    kc = link_index(ce, cs);
    link_entry[kp] = link_entry[kc];
    link_slot[kp] = link_slot[kc];
    slot_used[kc] = 1'b0;
  endfunction

  function automatic res_t apply_queue_action(logic [2:0] act, bit tv, bit [4:0] te,
                                              bit [1:0] ts, bit [4:0] p);
    res_t r;
    int i;
    int kt;
    int kn;
    int n;
    bit [4:0] he;
    bit [4:0] pe;
    bit [4:0] ce;
    bit [1:0] hs;
    bit [1:0] ps;
    bit [1:0] cs;
    bit hit;
    bit at_tail;
    r = '0;
    r.ntv = tv;
    r.nte = te;
    r.nts = ts;
    r.st = ST_OK;
    case (act)
      ACT_INSERT: begin
        i = 0;
        while (i < NSLOT && slot_used[link_index(p, 2'(i))]) i++;
        if (i == NSLOT) begin
          r.st = ST_NO_SLOT;
        end else begin
          kn = link_index(p, 2'(i));
          if (!tv) begin
            link_entry[kn] = p;
            link_slot[kn] = 2'(i);
          end else begin
            kt = link_index(te, ts);
            link_entry[kn] = link_entry[kt];
            link_slot[kn] = link_slot[kt];
            link_entry[kt] = p;
            link_slot[kt] = 2'(i);
          end
          slot_used[kn] = 1'b1;
          link_written[kn] = 1'b1;
          r.ntv = 1'b1;
          r.nte = p;
          r.nts = 2'(i);
        end
      end
      ACT_REMOVE_HEAD, ACT_PEEK: begin
        if (!tv) begin
          r.st = ST_FAIL;
        end else begin
          kt = link_index(te, ts);
          he = link_entry[kt];
          hs = link_slot[kt];
          r.fv = 1'b1;
          r.fe = he;
          if (act == ACT_REMOVE_HEAD) begin
            if (he == te && hs == ts) begin
              slot_used[kt] = 1'b0;
              r.ntv = 1'b0;
            end else begin
              unlink_after(te, ts, he, hs);
            end
          end
        end
      end
      ACT_REMOVE_NAMED: begin
        if (!tv) begin
          r.st = ST_FAIL;
        end else begin
          kt = link_index(te, ts);
          he = link_entry[kt];
          hs = link_slot[kt];
          if (he == te && hs == ts) begin
            if (te == p) begin
              slot_used[kt] = 1'b0;
              r.fv = 1'b1;
              r.fe = te;
              r.ntv = 1'b0;
            end else begin
              r.st = ST_FAIL;
            end
          end else begin
            pe = te;
            ps = ts;
            ce = he;
            cs = hs;
            n = 0;
            forever begin
              at_tail = (ce == te && cs == ts);
              hit = (ce == p);
              if (hit || at_tail || n >= NLINK) break;
              pe = ce;
              ps = cs;
              kn = link_index(ce, cs);
              ce = link_entry[kn];
              cs = link_slot[kn];
              n++;
            end
            if (!hit) begin
              r.st = ST_FAIL;
            end else begin
              unlink_after(pe, ps, ce, cs);
              r.fv = 1'b1;
              r.fe = ce;
              if (at_tail) begin
                r.nte = pe;
                r.nts = ps;
              end
            end
          end
        end
      end
      ACT_ALLOC: begin
        if (pool_count == 0) begin
          r.st = ST_FAIL;
        end else begin
          r.fv = 1'b1;
          r.fe = pool[pool_rd];
          pool_rd = (pool_rd + 1) % NENT;
          pool_count--;
        end
      end
      ACT_FREE: begin
        if (pool_count >= NENT) begin
          r.st = ST_FAIL;
        end else begin
          pool[pool_wr] = p;
          pool_wr = (pool_wr + 1) % NENT;
          pool_count++;
          for (i = 0; i < NSLOT; i++) slot_used[link_index(p, 2'(i))] = 1'b0;
        end
      end
      default: r.st = ST_FAIL;
    endcase
    if (!r.ntv) begin
      r.nte = '0;
      r.nts = '0;
    end
    if (!r.fv) r.fe = '0;
    return r;
  endfunction

  // Drives one request in the sender's burst pattern and records its expected result.
  task automatic send_request(logic [2:0] act, bit tv, bit [4:0] te, bit [1:0] ts,
                              bit [4:0] p, bit typed, res_t typed_exp, output res_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {p, ts, te, tv, act};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    r = apply_queue_action(act, tv, te, ts, p);
    pending_results.push_back(typed ? typed_exp : r);
  endtask

  task automatic check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $error("%s expected %0d actual %0d", name, exp_val, got_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("found_valid", int'(e.fv), int'(m_axis_tdata[0]));
        check_field("found_entry", int'(e.fe), int'(m_axis_tdata[5:1]));
        check_field("new_tail_valid", int'(e.ntv), int'(m_axis_tdata[6]));
        check_field("new_tail_entry", int'(e.nte), int'(m_axis_tdata[11:7]));
        check_field("new_tail_slot", int'(e.nts), int'(m_axis_tdata[13:12]));
        check_field("status", int'(e.st), int'(m_axis_tdata[15:14]));
      end
    end
  end

  int ready_run = 0;
  int stall_run = 0;
  always @(posedge clk) begin
    if (ready_run > 0) begin
      m_axis_tready <= 1'b1;
      ready_run--;
    end else if (stall_run > 0) begin
      m_axis_tready <= 1'b0;
      stall_run--;
    end else begin
      m_axis_tready <= 1'b1;
      ready_run = $urandom_range(1, 30);
      stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    res_t r;
    int n;
    int q;
    int pick;
    int k;
    int tries;
    logic [2:0] act;
    bit tv;
    bit [4:0] te;
    bit [1:0] ts;
    bit [4:0] p;
    for (n = 0; n < NENT; n++) pool[n] = 5'(n);
    for (n = 0; n < NQUEUE; n++) q_valid[n] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].act, dir_rows[i].tv, dir_rows[i].te, dir_rows[i].ts,
                   dir_rows[i].ent, dir_rows[i].typed, dir_rows[i].exp, r);
    end

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      q = $urandom_range(0, NQUEUE - 1);
      pick = $urandom_range(0, 99);
      tv = q_valid[q];
      te = q_entry[q];
      ts = q_slot[q];
      p = 5'($urandom_range(0, NENT - 1));
      if (pick < 32) begin
        act = ACT_INSERT;
      end else if (pick < 46) begin
        act = ACT_REMOVE_HEAD;
      end else if (pick < 54) begin
        act = ACT_PEEK;
      end else if (pick < 70) begin
        act = ACT_REMOVE_NAMED;
        case ($urandom_range(0, 2))
          0: p = q_last[q];
          1: p = q_entry[q];
          default: ;
        endcase
      end else if (pick < 80) begin
        act = ACT_ALLOC;
      end else if (pick < 90) begin
        act = ACT_FREE;
      end else begin
        // Noise: any code, any written link or an empty queue.
        act = 3'($urandom_range(0, 7));
        tv = 1'b0;
        te = 5'($urandom_range(0, NENT - 1));
        ts = 2'($urandom_range(0, NSLOT - 1));
        for (tries = 0; tries < 20 && $urandom_range(0, 4) != 0; tries++) begin
          k = $urandom_range(0, NLINK - 1);
          if (link_written[k]) begin
            tv = 1'b1;
            te = 5'(k / NSLOT);
            ts = 2'(k % NSLOT);
            break;
          end
        end
        q = -1;
      end
      send_request(act, tv, te, ts, p, 1'b0, '0, r);
      if (q >= 0 && act <= ACT_PEEK) begin
        q_valid[q] = r.ntv;
        q_entry[q] = r.nte;
        q_slot[q] = r.nts;
        if (act == ACT_INSERT && r.st == ST_OK) q_last[q] = p;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
